// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// property checked on every rising clock edge, reset included
`define PCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/pcd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcd_pkg
// shared types, constants and helpers of the percent escape decoder
// ----------------------------------------------------------------------------
package pcd_pkg;

  // the escape introducer, the register reset value and the digits of the 7F escape
  localparam logic [7:0] PctChar     = 8'h25;
  localparam logic [7:0] MarkerReset = 8'h7F;
  localparam logic [7:0] Char7       = 8'h37;
  localparam logic [7:0] CharUpperF  = 8'h46;

  // most results one byte can release
  localparam int unsigned MaxResults = 3;

  // default depth of the result queue, at least MaxResults
  localparam int unsigned QueueDepthDefault = 4;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       truncated_error;
    logic       last_out;
  } pcd_result_t;

  // results released by one byte, valid from index 0 upwards
  typedef struct packed {
    logic [1:0]             num;
    pcd_result_t [2:0]      res;
  } pcd_push_t;

  // hex digit lookup result
  typedef struct packed {
    logic       vld;
    logic [3:0] val;
  } hex_digit_t;

  // ascii hex digit to value, either case
  function automatic hex_digit_t hex_decode(logic [7:0] c);
    hex_digit_t h;
    h.vld = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.vld = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.vld = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

// ----- rtl/core/pcd_decode.sv -----
// ----------------------------------------------------------------------------
// pcd_decode
// escape state and single pass decode of one byte into up to three results
// ----------------------------------------------------------------------------
module pcd_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic [7:0]          in_byte_i,
  input  logic                last_byte_i,
  input  logic [7:0]          marker_i,
  output pcd_pkg::pcd_push_t  push_o
);

  // number of bytes held back
  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldPct  = 2'd1;
  localparam logic [1:0] HeldTwo  = 2'd2;

  logic [1:0]                   held_count_q, held_count_d;
  logic [7:0]                   held1_q, held1_d;
  logic [1:0]                   num;
  pcd_pkg::pcd_result_t [2:0]   res;
  pcd_pkg::hex_digit_t          hi, lo;
  logic [7:0]                   value;
  logic                         esc_ok;

  // escape check on the held digit and the new byte
  always_comb begin
    hi     = pcd_pkg::hex_decode(held1_q);
    lo     = pcd_pkg::hex_decode(in_byte_i);
    value  = {hi.val, lo.val};
    esc_ok = hi.vld && !hi.val[3] && lo.vld &&
             !(held1_q == pcd_pkg::Char7 && in_byte_i == pcd_pkg::CharUpperF) &&
             (value != marker_i);
  end

  // results and next held state
  always_comb begin
    held_count_d = held_count_q;
    held1_d      = held1_q;
    num          = 2'd0;
    res          = '0;
    unique case (held_count_q)
      HeldTwo: begin
        held_count_d = HeldNone;
        if (esc_ok) begin
          res[0].out_byte = value;
          num             = 2'd1;
        end else begin
          res[0].out_byte = pcd_pkg::PctChar;
          if (held1_q == pcd_pkg::PctChar) begin
            // held digit opens a new escape, new byte follows it
            held1_d      = in_byte_i;
            held_count_d = HeldTwo;
            num          = 2'd1;
          end else begin
            res[1].out_byte = held1_q;
            if (in_byte_i == pcd_pkg::PctChar) begin
              held_count_d = HeldPct;
              num          = 2'd2;
            end else begin
              res[2].out_byte = in_byte_i;
              num             = 2'd3;
            end
          end
        end
      end
      HeldPct: begin
        held1_d      = in_byte_i;
        held_count_d = HeldTwo;
      end
      HeldNone: begin
        if (in_byte_i == pcd_pkg::PctChar) begin
          held_count_d = HeldPct;
        end else begin
          res[0].out_byte = in_byte_i;
          num             = 2'd1;
        end
      end
      default: begin
        held_count_d = HeldNone;
      end
    endcase

    // end of stream: error when an escape is still open, else mark last
    if (last_byte_i) begin
      if (held_count_d != HeldNone) begin
        for (int k = 0; k < 3; k++) begin
          if (2'(k) == num) begin
            res[k].out_byte        = 8'd0;
            res[k].truncated_error = 1'b1;
            res[k].last_out        = 1'b1;
          end
        end
        num          = num + 2'd1;
        held_count_d = HeldNone;
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (2'(k + 1) == num) begin
            res[k].last_out = 1'b1;
          end
        end
      end
    end
  end

  assign push_o.num = adv_i ? num : 2'd0;
  assign push_o.res = res;

  // held count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= HeldNone;
    end else if (adv_i) begin
      held_count_q <= held_count_d;
    end
  end

  // held digit, read only after it was written
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      held1_q <= held1_d;
    end
  end

endmodule

// ----- rtl/core/pcd_outq.sv -----
// ----------------------------------------------------------------------------
// pcd_outq
// shifting result queue, up to three pushes and one pop per cycle
// ----------------------------------------------------------------------------
module pcd_outq #(
  parameter int unsigned Depth = pcd_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pcd_pkg::pcd_push_t    push_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pcd_pkg::pcd_result_t  head_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  pcd_pkg::pcd_result_t ent_q [Depth];
  pcd_pkg::pcd_result_t ent_d [Depth];
  logic [CntW-1:0]      count_q, count_d, base;
  logic                 pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign head_o      = ent_q[0];
  // space for the largest burst one byte can release
  assign room_o      = (count_q <= CntW'(Depth - pcd_pkg::MaxResults));

  // shift on transfer, then append the new results behind the rest
  always_comb begin
    ent_d = ent_q;
    if (pop) begin
      for (int i = 0; i < Depth - 1; i++) begin
        ent_d[i] = ent_q[i + 1];
      end
    end
    base = count_q - CntW'(pop);
    for (int i = 0; i < Depth; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < push_i.num && CntW'(i) == base + CntW'(k)) begin
          ent_d[i] = push_i.res[k];
        end
      end
    end
    count_d = base + CntW'(push_i.num);
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // queue entries
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ----- rtl/core/percent_escape_decoder.sv -----
// A transferred byte is held in the input register; its results are written into
// the result queue once the queue has room, and are offered from its head.
// Throughput: one byte per cycle while the result queue keeps three free
// entries; with fewer free, the input waits until results are taken out.
// Between input and output lie the input register, the escape decode and the queue.
// Reset clears the held escape, the input and queue valid state, and sets the
// marker register to 0x7F.
// ----------------------------------------------------------------------------
// percent_escape_decoder
// streaming percent escape decoder that, while its result queue has room, takes one byte in per cycle
// ----------------------------------------------------------------------------
module percent_escape_decoder #(
  parameter int unsigned QueueDepth = pcd_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       truncated_error_o,
  output logic       last_out_o
);

  logic                 in_vld_q, in_vld_d;
  logic [7:0]           in_byte_q;
  logic                 in_last_q;
  logic [7:0]           marker_q;
  logic                 room, adv, in_xfer;
  pcd_pkg::pcd_push_t   push;
  pcd_pkg::pcd_result_t head;

  // input register hand-off
  assign adv        = in_vld_q && room;
  assign in_ready_o = !in_vld_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_vld_d   = in_xfer ? 1'b1 : (adv ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      marker_q <= pcd_pkg::MarkerReset;
    end else begin
      in_vld_q <= in_vld_d;
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= in_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // escape decode
  pcd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_byte_i   (in_byte_q),
    .last_byte_i (in_last_q),
    .marker_i    (marker_q),
    .push_o      (push)
  );

  // result queue
  pcd_outq #(
    .Depth (QueueDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign out_byte_o        = head.out_byte;
  assign truncated_error_o = head.truncated_error;
  assign last_out_o        = head.last_out;

endmodule

// ----- rtl/core/pcd_checker.sv -----
// ----------------------------------------------------------------------------
// pcd_checker
// port level checks of the percent escape decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       truncated_error_o,
  input logic       last_out_o
);

  logic       in_stall, out_stall, err_out;
  logic [8:0] in_pay;
  logic [9:0] out_pay;

  // handshake views
  assign in_stall  = in_valid_i && !in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign err_out   = out_valid_o && truncated_error_o;
  assign in_pay    = {in_byte_i, last_byte_i};
  assign out_pay   = {out_byte_o, truncated_error_o, last_out_o};

  // stalled input stays offered and unchanged
  `PCD_ASSERT(a_in_hold, in_stall |=> in_valid_i && $stable(in_pay), "stalled input changed")

  // stalled result stays offered and unchanged
  `PCD_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_pay), "stalled result lost")

  // error result carries a zero byte and closes the stream
  `PCD_ASSERT(a_err_form, err_out |-> out_byte_o == 8'd0 && last_out_o, "bad error result")

  // after a reset cycle nothing is offered and the input is open
  `PCD_ASSERT_ALWAYS(a_rst_state, !rst_ni |=> !out_valid_o && in_ready_o, "not idle in reset")

endmodule

bind percent_escape_decoder pcd_checker u_pcd_checker (.*);

// ----- tb/percent_escape_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// percent_escape_decoder_tb
// drives escaped streams into the decoder, mostly under random idling on both
// handshakes, predicts every result from a behavioural decoder kept in step
// with each input transfer, and compares the results field by field in order
// ----------------------------------------------------------------------------
module percent_escape_decoder_tb;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned LongHold   = 48;
  localparam int unsigned HoldAfter  = 60;
  localparam int unsigned SettleWait = 8;
  localparam int unsigned PhaseItems = 70;

  // kinds of stimulus fragment that make up a random stream
  typedef enum int {
    FragEscape,
    FragMarker,
    FragSevenF,
    FragBroken,
    FragHighNibble,
    FragPlain
  } frag_kind_e;

  // one input byte waiting to be offered
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } esc_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_err;
  logic       out_last;

  // stimulus and expectation stores
  esc_byte_t            pending_bytes[$];
  pcd_pkg::pcd_result_t expected_results[$];
  pcd_pkg::pcd_result_t step_results[$];

  // decoder state as predicted
  logic [1:0] held_cnt = 2'd0;
  logic [7:0] held_nxt = 8'h00;
  logic [7:0] undef_marker = pcd_pkg::MarkerReset;

  int  items_queued = 0;
  int  items_taken = 0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  bit  hold_done = 1'b0;
  bit  quiet = 1'b0;

  percent_escape_decoder dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .in_byte_i         (in_byte),
    .last_byte_i       (in_last),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .out_byte_o        (out_byte),
    .truncated_error_o (out_err),
    .last_out_o        (out_last)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hex digit value, -1 for anything else
  function automatic int hex_val(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  // ascii digit for a nibble, letters in either case
  function automatic logic [7:0] hex_char(logic [3:0] n, logic upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // accept one byte while at most the escape introducer is held
  function automatic void absorb_byte(logic [7:0] b);
    if (held_cnt == 2'd0) begin
      if (b == pcd_pkg::PctChar) held_cnt = 2'd1;
      else step_results.push_back('{out_byte: b, truncated_error: 1'b0, last_out: 1'b0});
    end else begin
      held_nxt = b;
      held_cnt = 2'd2;
    end
  endfunction

  // work out the results one transferred byte releases
  function automatic void decode_transfer(logic [7:0] b, logic last);
    int         hi;
    int         lo;
    logic       ok;
    logic [7:0] value;
    logic [7:0] h1;
    step_results.delete();
    if (held_cnt == 2'd2) begin
      h1 = held_nxt;
      hi = hex_val(h1);
      lo = hex_val(b);
      ok = hi >= 0 && hi <= 7 && lo >= 0 &&
           !(h1 == pcd_pkg::Char7 && b == pcd_pkg::CharUpperF);
      value = ok ? 8'((hi << 4) | lo) : 8'h00;
      if (ok && value == undef_marker) ok = 1'b0;
      held_cnt = 2'd0;
      if (ok) begin
        step_results.push_back('{out_byte: value, truncated_error: 1'b0, last_out: 1'b0});
      end else begin
        // refused escape: release the introducer, look at the two bytes again
        step_results.push_back('{out_byte: pcd_pkg::PctChar, truncated_error: 1'b0,
                                 last_out: 1'b0});
        absorb_byte(h1);
        absorb_byte(b);
      end
    end else begin
      absorb_byte(b);
    end
    // end of stream: truncation error or mark the final result
    if (last) begin
      if (held_cnt != 2'd0 || step_results.size() == 0) begin
        held_cnt = 2'd0;
        step_results.push_back('{out_byte: 8'h00, truncated_error: 1'b1, last_out: 1'b1});
      end else begin
        step_results[step_results.size() - 1].last_out = 1'b1;
      end
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  function automatic void note_mismatch(string what, pcd_pkg::pcd_result_t want,
                                        pcd_pkg::pcd_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected byte %02h err %0b last %0b, got byte %02h err %0b last %0b",
               $time, what, want.out_byte, want.truncated_error, want.last_out,
               got.out_byte, got.truncated_error, got.last_out);
  endfunction

  // sender: offers pending bytes, with random gaps
  always @(posedge clk) begin
    logic      take;
    esc_byte_t nxt;
    if (rst_n) begin
      take = in_valid && in_ready;
      if (take) begin
        decode_transfer(in_byte, in_last);
        items_taken <= items_taken + 1;
      end
      if (!in_valid || take) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 6) - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          nxt = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte <= nxt.data;
          in_last <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    logic rdy;
    if (rst_n) begin
      if (!hold_done && results_seen >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rdy = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 6) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    pcd_pkg::pcd_result_t got;
    pcd_pkg::pcd_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_byte: out_byte, truncated_error: out_err, last_out: out_last};
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", got, got);
      end else begin
        want = expected_results.pop_front();
        if (got.out_byte != want.out_byte || got.truncated_error != want.truncated_error ||
            got.last_out != want.last_out)
          note_mismatch("wrong result", want, got);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("timeout after %0d cycles without a transfer", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic queue_byte(logic [7:0] b, logic last);
    pending_bytes.push_back('{data: b, last: last});
    items_queued++;
  endtask

  task automatic queue_text(string s, logic last);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], last && i == s.len() - 1);
  endtask

  // random streams of well-formed, refused and broken escapes and plain bytes
  task automatic load_streams(int count);
    logic [7:0] text[$];
    frag_kind_e kind;
    int         pick;
    int         frags;
    int         queued;
    queued = 0;
    while (queued < count) begin
      text.delete();
      frags = $urandom_range(1, 8);
      for (int f = 0; f < frags; f++) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0, 1, 2, 3: kind = FragEscape;
          4:          kind = FragMarker;
          5:          kind = FragSevenF;
          6:          kind = FragBroken;
          7:          kind = FragHighNibble;
          default:    kind = FragPlain;
        endcase
        case (kind)
          FragEscape: begin
            text.push_back(pcd_pkg::PctChar);
            text.push_back(hex_char(4'($urandom_range(0, 7)), 1'($urandom)));
            text.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom)));
          end
          FragMarker: begin
            text.push_back(pcd_pkg::PctChar);
            text.push_back(hex_char(undef_marker[7:4], 1'($urandom)));
            text.push_back(hex_char(undef_marker[3:0], 1'($urandom)));
          end
          FragSevenF: begin
            text.push_back(pcd_pkg::PctChar);
            text.push_back(pcd_pkg::Char7);
            text.push_back(pcd_pkg::CharUpperF);
          end
          FragBroken: begin
            text.push_back(pcd_pkg::PctChar);
            text.push_back(8'($urandom_range(0, 255)));
            text.push_back(8'($urandom_range(0, 255)));
          end
          FragHighNibble: begin
            text.push_back(pcd_pkg::PctChar);
            text.push_back(hex_char(4'($urandom_range(8, 15)), 1'($urandom)));
            text.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom)));
          end
          default: text.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      // now and then cut an escape short at the end of the stream
      if ($urandom_range(0, 5) == 0) begin
        text.push_back(pcd_pkg::PctChar);
        if ($urandom_range(0, 1) == 1)
          text.push_back(hex_char(4'($urandom_range(0, 7)), 1'($urandom)));
      end
      foreach (text[i]) queue_byte(text[i], i == text.size() - 1);
      queued += text.size();
    end
  endtask

  // wait until every byte is taken and every result has come out
  task automatic wait_drained();
    while (items_taken != items_queued || expected_results.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic write_marker(logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    undef_marker = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sequence of phases
  initial begin
    logic [7:0] markers[$];
    markers = '{8'h00, 8'hFF, 8'h41, 8'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                pcd_pkg::MarkerReset};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed cases with the marker at its reset value
    queue_text("%41", 1'b0);
    queue_text("%7F", 1'b0);
    queue_text("%7f", 1'b0);
    queue_text("%00", 1'b0);
    queue_text("%%41", 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_text("%8A", 1'b1);
    queue_byte(8'h80, 1'b0);
    queue_text("%", 1'b1);
    queue_text("%4", 1'b1);
    queue_text("%%%", 1'b1);
    wait_drained();

    // random phases, one marker setting each, the last one without idling
    foreach (markers[p]) begin
      write_marker(markers[p]);
      if (p == markers.size() - 1) quiet <= 1'b1;
      load_streams(PhaseItems);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
